// ===== design/log_segment_write_allocator_core_defines.svh =====
// assertion macros shared by the log segment write allocator modules
`ifndef LOG_SEGMENT_WRITE_ALLOCATOR_CORE_DEFINES_SVH
`define LOG_SEGMENT_WRITE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a condition at every clock edge outside reset
`define LSWA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// check that a condition is followed by another in the next cycle
`define LSWA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LSWA_ASSERT_ALWAYS(label, expr, msg)
`define LSWA_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== design/lswa_pkg.sv =====
// types, codes and defaults for the log segment write allocator
package lswa_pkg;

    // default geometry
    localparam int SEGMENTS_DEF           = 64;
    localparam int BLOCKS_PER_SEGMENT_DEF = 32;
    localparam int DATA_BLOCKS_DEF        = 31;

    // request codes
    localparam logic [2:0] REQ_DATA   = 3'd0;
    localparam logic [2:0] REQ_INODE  = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_SET    = 3'd3;
    localparam logic [2:0] REQ_START  = 3'd4;
    localparam logic [2:0] REQ_FLUSH  = 3'd5;
    localparam logic [2:0] REQ_CLEAR  = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_SEQ_END = 2'd2;

    // request word
    typedef struct packed {
        logic [2:0] req_type;
        logic [5:0] segment_index;
        logic       segment_used;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [10:0] alloc_addr;
        logic [4:0]  imap_slot;
        logic        flushed;
        logic [5:0]  flushed_segment;
        logic [1:0]  status;
        logic [5:0]  current_segment;
        logic [4:0]  current_block;
        logic [4:0]  imap_count;
    } t_out_word;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic exec;
        logic srch_chk;
        logic clr;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic go_search;
        logic go_clear;
        logic found;
        logic srch_last;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/log_segment_write_allocator_core.sv =====
// Log segment write allocator, top level.
// Request words come in on i_in_valid / o_in_ready and result words leave on
// o_out_valid / i_out_ready; each request gives exactly one result word.
// The one configuration bit (thorough mode) is written through i_cfg_we with
// i_cfg_wdata and takes effect at that clock edge.
// A plain request passes through the execute and done states; the block takes
// no new word until the previous result is in the output register. A segment
// close in search mode walks the segment bitmap ram one entry at a time, with
// a read state and then a check state for each entry. A clear-map request
// sweeps the bitmap ram one entry a cycle.
// Reset (i_rst_n low, synchronous) zeroes the write pointer and the mode bit,
// then a sweep clears the bitmap ram; o_in_ready stays low until it ends,
// while configuration writes are still taken.
// The result sits in an output register; a new word is accepted while it
// waits, and a finished result that finds the register still full is held
// until the receiver takes the earlier one.
module log_segment_write_allocator_core #(
    parameter int SEGMENTS                = lswa_pkg::SEGMENTS_DEF,
    parameter int BLOCKS_PER_SEGMENT      = lswa_pkg::BLOCKS_PER_SEGMENT_DEF,
    parameter int DATA_BLOCKS_PER_SEGMENT = lswa_pkg::DATA_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lswa_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lswa_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    lswa_pkg::t_ctrl_cmd w_cmd;
    lswa_pkg::t_dp_sts   w_sts;

    // sequencing
    lswa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // pointer, bitmap and result datapath
    lswa_dp #(
        .SEGMENTS                (SEGMENTS),
        .BLOCKS_PER_SEGMENT      (BLOCKS_PER_SEGMENT),
        .DATA_BLOCKS_PER_SEGMENT (DATA_BLOCKS_PER_SEGMENT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== design/lswa_ram.sv =====
// generic single write port ram with registered read
module lswa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = lswa_pkg::SEGMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lswa_ctrl.sv =====
// controller state machine sequencing requests, searches and map sweeps
`include "log_segment_write_allocator_core_defines.svh"

module lswa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lswa_pkg::t_dp_sts   i_sts,
    output lswa_pkg::t_ctrl_cmd o_cmd
);

    lswa_pkg::t_state r_state;
    lswa_pkg::t_state n_state;

    // state register, reset starts the map sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lswa_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lswa_pkg::ST_INIT: begin
                if (i_sts.clr_last) begin
                    n_state = lswa_pkg::ST_IDLE;
                end
            end
            lswa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lswa_pkg::ST_EXEC;
                end
            end
            lswa_pkg::ST_EXEC: begin
                if (i_sts.go_clear) begin
                    n_state = lswa_pkg::ST_CLEAR;
                end else if (i_sts.go_search) begin
                    n_state = lswa_pkg::ST_SRCH_RD;
                end else begin
                    n_state = lswa_pkg::ST_DONE;
                end
            end
            lswa_pkg::ST_SRCH_RD: begin
                n_state = lswa_pkg::ST_SRCH_CHK;
            end
            lswa_pkg::ST_SRCH_CHK: begin
                if (i_sts.found || i_sts.srch_last) begin
                    n_state = lswa_pkg::ST_DONE;
                end else begin
                    n_state = lswa_pkg::ST_SRCH_RD;
                end
            end
            lswa_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = lswa_pkg::ST_DONE;
                end
            end
            lswa_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = lswa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lswa_pkg::ST_INIT;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready      = (r_state == lswa_pkg::ST_IDLE);
        o_cmd.accept    = (r_state == lswa_pkg::ST_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == lswa_pkg::ST_EXEC);
        o_cmd.srch_chk  = (r_state == lswa_pkg::ST_SRCH_CHK);
        o_cmd.clr       = (r_state == lswa_pkg::ST_INIT) || (r_state == lswa_pkg::ST_CLEAR);
        o_cmd.out_load  = (r_state == lswa_pkg::ST_DONE) && i_sts.out_free;
    end

    // a request is executed in a single cycle
    `LSWA_ASSERT_NEXT(a_exec_once, r_state == lswa_pkg::ST_EXEC,
        r_state != lswa_pkg::ST_EXEC, "exec held")
    // every bitmap read is followed by its check
    `LSWA_ASSERT_NEXT(a_rd_then_chk, r_state == lswa_pkg::ST_SRCH_RD,
        r_state == lswa_pkg::ST_SRCH_CHK, "read not checked")
    // the end of a clear sweep leads to the result
    `LSWA_ASSERT_NEXT(a_clr_to_done, r_state == lswa_pkg::ST_CLEAR && i_sts.clr_last,
        r_state == lswa_pkg::ST_DONE, "clear sweep not finished")

endmodule

// ===== design/lswa_dp.sv =====
// datapath: write pointer, bitmap ram, free search and result register
`include "log_segment_write_allocator_core_defines.svh"

module lswa_dp #(
    parameter int SEGMENTS                = lswa_pkg::SEGMENTS_DEF,
    parameter int BLOCKS_PER_SEGMENT      = lswa_pkg::BLOCKS_PER_SEGMENT_DEF,
    parameter int DATA_BLOCKS_PER_SEGMENT = lswa_pkg::DATA_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lswa_pkg::t_ctrl_cmd i_cmd,
    output lswa_pkg::t_dp_sts   o_sts,
    input  lswa_pkg::t_in_word  i_in_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lswa_pkg::t_out_word o_out_word
);

    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int CNT_W  = $clog2(DATA_BLOCKS_PER_SEGMENT + 1);
    localparam int ADDR_W = $clog2(SEGMENTS * BLOCKS_PER_SEGMENT + DATA_BLOCKS_PER_SEGMENT);

    // architectural state
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [CNT_W-1:0] r_blk, n_blk;
    logic [CNT_W-1:0] r_imap, n_imap;
    logic             r_thorough, n_thorough;

    // working registers
    lswa_pkg::t_in_word  r_req, n_req;
    lswa_pkg::t_out_word r_res, n_res;
    lswa_pkg::t_out_word r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [SEG_W-1:0]    r_cand, n_cand;
    logic [SEG_W-1:0]    r_cnt, n_cnt;
    logic [SEG_W-1:0]    r_clr, n_clr;

    // bitmap ram port
    logic             w_we;
    logic [SEG_W-1:0] w_waddr;
    logic             w_wdata;
    logic             w_rdata;

    // request decode and pointer arithmetic
    logic              w_blk_req, w_appends, w_takes_slot, w_full, w_idx_ok;
    logic [CNT_W:0]    w_imap_inc, w_blk_inc;
    logic [SEG_W:0]    w_seg_inc;
    logic [ADDR_W-1:0] w_addr;
    logic [SEG_W-1:0]  w_seg_wrap, w_cand_wrap;

    lswa_ram #(
        .WIDTH (1),
        .DEPTH (SEGMENTS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cand),
        .o_rdata (w_rdata)
    );

    // decode and arithmetic on the held request
    always_comb begin
        w_blk_req    = r_req.req_type inside {lswa_pkg::REQ_DATA, lswa_pkg::REQ_INODE,
                                              lswa_pkg::REQ_REMOVE};
        w_appends    = r_req.req_type inside {lswa_pkg::REQ_DATA, lswa_pkg::REQ_INODE};
        w_takes_slot = r_req.req_type inside {lswa_pkg::REQ_INODE, lswa_pkg::REQ_REMOVE};
        w_imap_inc   = {1'b0, r_imap} + (CNT_W+1)'(w_takes_slot);
        w_blk_inc    = {1'b0, r_blk} + (CNT_W+1)'(1);
        w_full       = (w_blk_inc >= (CNT_W+1)'(DATA_BLOCKS_PER_SEGMENT)) ||
                       (w_imap_inc >= (CNT_W+1)'(DATA_BLOCKS_PER_SEGMENT));
        w_seg_inc    = {1'b0, r_seg} + (SEG_W+1)'(1);
        w_seg_wrap   = (r_seg == SEG_W'(SEGMENTS - 1)) ? '0 : SEG_W'(w_seg_inc);
        w_cand_wrap  = (r_cand == SEG_W'(SEGMENTS - 1)) ? '0 : (r_cand + SEG_W'(1));
        w_idx_ok     = 32'(r_req.segment_index) < 32'(SEGMENTS);
        w_addr       = ADDR_W'(r_seg) * ADDR_W'(BLOCKS_PER_SEGMENT) + ADDR_W'(r_blk);
    end

    // status to the controller
    always_comb begin
        o_sts.go_search = w_blk_req && w_full && !r_thorough;
        o_sts.go_clear  = (r_req.req_type == lswa_pkg::REQ_CLEAR);
        o_sts.found     = !w_rdata;
        o_sts.srch_last = (r_cnt == SEG_W'(SEGMENTS - 1));
        o_sts.clr_last  = (r_clr == SEG_W'(SEGMENTS - 1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // next values
    always_comb begin
        n_seg       = r_seg;
        n_blk       = r_blk;
        n_imap      = r_imap;
        n_thorough  = r_thorough;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_cand      = r_cand;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_seg;
        w_wdata     = 1'b1;

        // configuration write
        if (i_cfg_we) begin
            n_thorough = i_cfg_wdata;
        end

        // map sweep, one entry a cycle
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 1'b0;
            n_clr   = o_sts.clr_last ? '0 : (r_clr + SEG_W'(1));
        end

        // take a request word
        if (i_cmd.accept) begin
            n_req = i_in_word;
        end

        // execute the request
        if (i_cmd.exec) begin
            n_res.alloc_addr      = w_appends ? 11'(w_addr) : '0;
            n_res.imap_slot       = w_takes_slot ? 5'(r_imap) : '0;
            n_res.flushed         = 1'b0;
            n_res.flushed_segment = '0;
            n_res.status          = lswa_pkg::STAT_OK;
            n_clr                 = '0;
            case (r_req.req_type)
                lswa_pkg::REQ_DATA, lswa_pkg::REQ_INODE, lswa_pkg::REQ_REMOVE: begin
                    if (w_full) begin
                        // close the segment and mark it used
                        n_res.flushed         = 1'b1;
                        n_res.flushed_segment = 6'(r_seg);
                        w_we                  = 1'b1;
                        if (r_thorough) begin
                            if (w_seg_inc < (SEG_W+1)'(SEGMENTS)) begin
                                n_seg  = SEG_W'(w_seg_inc);
                                n_blk  = '0;
                                n_imap = '0;
                            end else begin
                                n_res.status = lswa_pkg::STAT_SEQ_END;
                            end
                        end else begin
                            n_cand = w_seg_wrap;
                            n_cnt  = SEG_W'(1);
                        end
                    end else begin
                        n_imap = CNT_W'(w_imap_inc);
                        if (w_appends) begin
                            n_blk = CNT_W'(w_blk_inc);
                        end
                    end
                end
                lswa_pkg::REQ_SET: begin
                    if (w_idx_ok) begin
                        w_we    = 1'b1;
                        w_waddr = SEG_W'(r_req.segment_index);
                        w_wdata = r_req.segment_used;
                    end
                end
                lswa_pkg::REQ_START: begin
                    if (w_idx_ok) begin
                        n_seg  = SEG_W'(r_req.segment_index);
                        n_blk  = '0;
                        n_imap = '0;
                    end
                end
                lswa_pkg::REQ_FLUSH: begin
                    w_we                  = 1'b1;
                    n_res.flushed         = 1'b1;
                    n_res.flushed_segment = 6'(r_seg);
                end
                default: begin
                end
            endcase
            n_res.current_segment = 6'(n_seg);
            n_res.current_block   = 5'(n_blk);
            n_res.imap_count      = 5'(n_imap);
        end

        // check one bitmap entry of the circular search
        if (i_cmd.srch_chk) begin
            if (o_sts.found) begin
                n_seg                 = r_cand;
                n_blk                 = '0;
                n_imap                = '0;
                n_res.current_segment = 6'(r_cand);
                n_res.current_block   = '0;
                n_res.imap_count      = '0;
            end else if (o_sts.srch_last) begin
                n_res.status = lswa_pkg::STAT_NO_FREE;
            end else begin
                n_cnt  = r_cnt + SEG_W'(1);
                n_cand = w_cand_wrap;
            end
        end

        // output register
        if (i_cmd.out_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= '0;
            r_blk       <= '0;
            r_imap      <= '0;
            r_thorough  <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg       <= n_seg;
            r_blk       <= n_blk;
            r_imap      <= n_imap;
            r_thorough  <= n_thorough;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_out  <= n_out;
        r_cand <= n_cand;
        r_cnt  <= n_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // block slot never reaches the data block count
    `LSWA_ASSERT_ALWAYS(a_blk_range, r_blk < CNT_W'(DATA_BLOCKS_PER_SEGMENT),
        "block slot overrun")
    // imap count never reaches the data block count
    `LSWA_ASSERT_ALWAYS(a_imap_range, r_imap < CNT_W'(DATA_BLOCKS_PER_SEGMENT),
        "imap overrun")
    // a failure status only comes with a segment close
    `LSWA_ASSERT_ALWAYS(a_fail_flushed,
        !r_out_valid || r_out.status == lswa_pkg::STAT_OK || r_out.flushed,
        "failure without close")

endmodule
